// ----- sv/nrv2b_pkg.sv -----
package nrv2b_pkg;

    localparam int unsigned HIST_DEPTH = 65536;
    localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
    localparam int unsigned MAX_RUN    = 64;
    localparam int unsigned RUN_AW     = $clog2(MAX_RUN);
    localparam int unsigned RUN_CW     = RUN_AW + 1;

    localparam logic [31:0] OFF_LONG   = 32'h0000_0D00;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [32:0] HIST_LIMIT = 33'(HIST_DEPTH);

    localparam logic OP_FEED  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] ST_DECODING = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    localparam logic [1:0] FWS_16 = 2'd2;
    localparam logic [1:0] FWS_32 = 2'd3;

    typedef enum logic [3:0] {
        PH_FLAG       = 4'd0,
        PH_LIT        = 4'd1,
        PH_OFF_BIT    = 4'd2,
        PH_OFF_END    = 4'd3,
        PH_OFF_LOW    = 4'd4,
        PH_LEN_A      = 4'd5,
        PH_LEN_B      = 4'd6,
        PH_LEN_G_BIT  = 4'd7,
        PH_LEN_G_END  = 4'd8,
        PH_COPY_START = 4'd9,
        PH_COPY       = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_STEP,
        CS_CPWR,
        CS_OUTRD,
        CS_OUTSHOW
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic cp_write;
        logic out_read;
        logic out_next;
    } dp_cmd_t;

    typedef struct packed {
        logic step_break;
        logic step_copy;
        logic out_last;
    } dp_stat_t;

    function automatic logic [31:0] flag_hit(input logic [1:0] sel);
        logic [31:0] r;
        case (sel)
            FWS_16:  r = 32'h0000_8000;
            FWS_32:  r = 32'h8000_0000;
            default: r = 32'h0000_0080;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/nrv2b_ctrl.sv -----
module nrv2b_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  nrv2b_pkg::dp_stat_t stat,
    output nrv2b_pkg::dp_cmd_t  cmd
);
    import nrv2b_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = CS_STEP;
                end
            end
            CS_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.step_copy)
                begin
                    state_next = CS_CPWR;
                end
                else if (stat.step_break)
                begin
                    state_next = CS_OUTRD;
                end
            end
            CS_CPWR:
            begin
                cmd.cp_write = 1'b1;
                state_next   = CS_STEP;
            end
            CS_OUTRD:
            begin
                cmd.out_read = 1'b1;
                state_next   = CS_OUTSHOW;
            end
            CS_OUTSHOW:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.out_next = 1'b1;
                    state_next   = stat.out_last ? CS_IDLE : CS_OUTRD;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/nrv2b_datapath.sv -----
module nrv2b_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    input  logic                op,
    input  logic [7:0]          in_byte,
    input  nrv2b_pkg::dp_cmd_t  cmd,
    output nrv2b_pkg::dp_stat_t stat,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                last_in_run,
    output logic                copy_pending,
    output logic [1:0]          status
);
    import nrv2b_pkg::*;

    logic [1:0]        fws_reg, fws_next;
    logic [31:0]       shift_reg, shift_next;
    logic [1:0]        idx_reg, idx_next;
    logic [31:0]       gather_reg, gather_next;
    phase_t            phase_reg, phase_next;
    logic [31:0]       gamma_reg, gamma_next;
    logic [31:0]       last_off_reg, last_off_next;
    logic [31:0]       off_reg, off_next;
    logic [31:0]       len_reg, len_next;
    logic [31:0]       remain_reg, remain_next;
    logic [31:0]       count_reg, count_next;
    logic [1:0]        status_reg, status_next;
    logic [HIST_AW-1:0] hpos_reg, hpos_next;
    logic              have_reg, have_next;
    logic [7:0]        byte_reg, byte_next;
    logic [RUN_CW-1:0] n_reg, n_next;
    logic [RUN_CW-1:0] k_reg, k_next;

    logic [7:0]        hist_mem [HIST_DEPTH];
    logic [7:0]        run_mem [MAX_RUN];
    logic [7:0]        hist_rdata_reg;
    logic [7:0]        run_rdata_reg;

    logic              emit_en;
    logic [7:0]        emit_data;
    logic              hist_re;
    logic [HIST_AW-1:0] hist_raddr;

    logic [31:0]       hit;
    logic [31:0]       mask;
    logic [2:0]        nbytes;
    logic [32:0]       fl_reg;
    logic              fl_ok;
    logic              fl_bit;
    logic [31:0]       gather_new;
    logic [2:0]        idx_inc;
    logic [31:0]       low_v;
    logic [31:0]       total;
    logic              pending_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fws_reg      <= 2'd1;
            shift_reg    <= 32'h0000_0080;
            idx_reg      <= '0;
            gather_reg   <= '0;
            phase_reg    <= PH_FLAG;
            gamma_reg    <= 32'd1;
            last_off_reg <= 32'd1;
            off_reg      <= '0;
            len_reg      <= '0;
            remain_reg   <= '0;
            count_reg    <= '0;
            status_reg   <= ST_DECODING;
            hpos_reg     <= '0;
            have_reg     <= 1'b0;
            n_reg        <= '0;
            k_reg        <= '0;
        end
        else
        begin
            fws_reg      <= fws_next;
            shift_reg    <= shift_next;
            idx_reg      <= idx_next;
            gather_reg   <= gather_next;
            phase_reg    <= phase_next;
            gamma_reg    <= gamma_next;
            last_off_reg <= last_off_next;
            off_reg      <= off_next;
            len_reg      <= len_next;
            remain_reg   <= remain_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            hpos_reg     <= hpos_next;
            have_reg     <= have_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            hist_mem[hpos_reg] <= emit_data;
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            run_mem[n_reg[RUN_AW-1:0]] <= emit_data;
        end
        if (cmd.out_read)
        begin
            run_rdata_reg <= run_mem[k_reg[RUN_AW-1:0]];
        end
    end

    always_comb
    begin
        case (fws_reg)
            FWS_16:
            begin
                mask   = 32'h0000_FFFF;
                nbytes = 3'd2;
            end
            FWS_32:
            begin
                mask   = 32'hFFFF_FFFF;
                nbytes = 3'd4;
            end
            default:
            begin
                mask   = 32'h0000_00FF;
                nbytes = 3'd1;
            end
        endcase
        hit        = flag_hit(fws_reg);
        gather_new = gather_reg | (32'(byte_reg) << {idx_reg, 3'b000});
        idx_inc    = {1'b0, idx_reg} + 3'd1;
        if (shift_reg == hit)
        begin
            fl_reg = {gather_new, 1'b1};
        end
        else
        begin
            fl_reg = {shift_reg, 1'b0};
        end
        case (fws_reg)
            FWS_16:  fl_bit = fl_reg[16];
            FWS_32:  fl_bit = fl_reg[32];
            default: fl_bit = fl_reg[8];
        endcase
        low_v       = ((gamma_reg - 32'd3) << 8) | 32'(byte_reg);
        total       = len_reg + ((off_reg > OFF_LONG) ? 32'd1 : 32'd0) + 32'd1;
        hist_raddr  = hpos_reg - off_reg[HIST_AW-1:0];
        pending_now = (phase_reg == PH_COPY) && (remain_reg != 32'd0);
    end

    always_comb
    begin
        fws_next      = fws_reg;
        shift_next    = shift_reg;
        idx_next      = idx_reg;
        gather_next   = gather_reg;
        phase_next    = phase_reg;
        gamma_next    = gamma_reg;
        last_off_next = last_off_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        remain_next   = remain_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        hpos_next     = hpos_reg;
        have_next     = have_reg;
        byte_next     = byte_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        emit_en       = 1'b0;
        emit_data     = byte_reg;
        hist_re       = 1'b0;
        fl_ok         = 1'b0;
        stat          = '0;

        if (cmd.accept)
        begin
            have_next = (op == OP_FEED) && !pending_now;
            byte_next = in_byte;
            n_next    = '0;
            k_next    = '0;
        end

        if (cmd.step)
        begin
            if (status_reg != ST_DECODING)
            begin
                stat.step_break = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_LIT:
                    begin
                        if (!have_reg || n_reg == RUN_CW'(MAX_RUN))
                        begin
                            stat.step_break = 1'b1;
                        end
                        else
                        begin
                            emit_en    = 1'b1;
                            have_next  = 1'b0;
                            phase_next = PH_FLAG;
                        end
                    end
                    PH_OFF_LOW:
                    begin
                        if (!have_reg)
                        begin
                            stat.step_break = 1'b1;
                        end
                        else
                        begin
                            have_next = 1'b0;
                            if (low_v == ALL_ONES)
                            begin
                                status_next     = ST_END;
                                stat.step_break = 1'b1;
                            end
                            else
                            begin
                                off_next      = low_v + 32'd1;
                                last_off_next = low_v + 32'd1;
                                phase_next    = PH_LEN_A;
                            end
                        end
                    end
                    PH_COPY_START:
                    begin
                        if (off_reg > count_reg || {1'b0, off_reg} > HIST_LIMIT)
                        begin
                            status_next     = ST_ERROR;
                            stat.step_break = 1'b1;
                        end
                        else
                        begin
                            remain_next = total;
                            phase_next  = PH_COPY;
                        end
                    end
                    PH_COPY:
                    begin
                        if (remain_reg == 32'd0)
                        begin
                            phase_next = PH_FLAG;
                        end
                        else if (n_reg == RUN_CW'(MAX_RUN))
                        begin
                            stat.step_break = 1'b1;
                        end
                        else
                        begin
                            hist_re        = 1'b1;
                            stat.step_copy = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (shift_reg == hit)
                        begin
                            if (!have_reg)
                            begin
                                stat.step_break = 1'b1;
                            end
                            else
                            begin
                                have_next = 1'b0;
                                if (idx_inc == nbytes)
                                begin
                                    gather_next = '0;
                                    idx_next    = '0;
                                    fl_ok       = 1'b1;
                                end
                                else
                                begin
                                    gather_next     = gather_new;
                                    idx_next        = idx_inc[1:0];
                                    stat.step_break = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            fl_ok = 1'b1;
                        end
                        if (fl_ok)
                        begin
                            shift_next = fl_reg[31:0] & mask;
                            case (phase_reg)
                                PH_FLAG:
                                begin
                                    if (fl_bit)
                                    begin
                                        phase_next = PH_LIT;
                                    end
                                    else
                                    begin
                                        gamma_next = 32'd1;
                                        phase_next = PH_OFF_BIT;
                                    end
                                end
                                PH_OFF_BIT:
                                begin
                                    gamma_next = {gamma_reg[30:0], fl_bit};
                                    phase_next = PH_OFF_END;
                                end
                                PH_OFF_END:
                                begin
                                    if (!fl_bit)
                                    begin
                                        phase_next = PH_OFF_BIT;
                                    end
                                    else if (gamma_reg == 32'd2)
                                    begin
                                        off_next   = last_off_reg;
                                        phase_next = PH_LEN_A;
                                    end
                                    else
                                    begin
                                        phase_next = PH_OFF_LOW;
                                    end
                                end
                                PH_LEN_A:
                                begin
                                    len_next   = 32'(fl_bit);
                                    phase_next = PH_LEN_B;
                                end
                                PH_LEN_B:
                                begin
                                    if ({len_reg[30:0], fl_bit} == 32'd0)
                                    begin
                                        len_next   = 32'd1;
                                        phase_next = PH_LEN_G_BIT;
                                    end
                                    else
                                    begin
                                        len_next   = {len_reg[30:0], fl_bit};
                                        phase_next = PH_COPY_START;
                                    end
                                end
                                PH_LEN_G_BIT:
                                begin
                                    len_next   = {len_reg[30:0], fl_bit};
                                    phase_next = PH_LEN_G_END;
                                end
                                PH_LEN_G_END:
                                begin
                                    if (!fl_bit)
                                    begin
                                        phase_next = PH_LEN_G_BIT;
                                    end
                                    else
                                    begin
                                        len_next   = len_reg + 32'd2;
                                        phase_next = PH_COPY_START;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_FLAG;
                                end
                            endcase
                        end
                    end
                endcase
            end
        end

        if (cmd.cp_write)
        begin
            emit_en     = 1'b1;
            emit_data   = hist_rdata_reg;
            remain_next = remain_reg - 32'd1;
        end

        if (emit_en)
        begin
            hpos_next = hpos_reg + HIST_AW'(1);
            n_next    = n_reg + RUN_CW'(1);
            if (count_reg != ALL_ONES)
            begin
                count_next = count_reg + 32'd1;
            end
        end

        if (cmd.out_next)
        begin
            k_next = k_reg + RUN_CW'(1);
        end

        stat.out_last = (n_reg == '0) || (k_reg == n_reg - RUN_CW'(1));

        if (cfg_wr_en)
        begin
            fws_next    = cfg_wr_data;
            shift_next  = flag_hit(cfg_wr_data);
            idx_next    = '0;
            gather_next = '0;
        end
    end

    assign out_byte     = (n_reg == '0) ? 8'd0 : run_rdata_reg;
    assign byte_valid   = (n_reg != '0);
    assign last_in_run  = stat.out_last;
    assign copy_pending = (status_reg == ST_DECODING) && pending_now;
    assign status       = status_reg;

endmodule

// ----- sv/nrv2b_lz_decompressor.sv -----
// channel   signals                          item
// input     in_valid / in_stall              op, in_byte
// output    out_valid / out_stall            out_byte, byte_valid, last_in_run,
//                                            copy_pending, status
// config    cfg_wr_en / cfg_wr_data          flag_word_size
//
// one item at a time: each decode step (flag bit, offset or length step) is a STEP state,
// each copied byte a history memory read then write (STEP, then CPWR), then each
// result played out of the run buffer a read then a show (OUTRD, then OUTSHOW), held while out_stall is high
// rst_n clears the decode state but the held input byte; history and run memory contents are not cleared
// in_stall is high from accept until the item's last result is taken
module nrv2b_lz_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_in_run,
    output logic       copy_pending,
    output logic [1:0] status
);
    import nrv2b_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    nrv2b_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    nrv2b_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .op           (op),
        .in_byte      (in_byte),
        .cmd          (cmd),
        .stat         (stat),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .last_in_run  (last_in_run),
        .copy_pending (copy_pending),
        .status       (status)
    );

endmodule
